// ===== sv/encmv_pkg.sv =====
// Shared types and constants for the encoder move controller.
package encmv_pkg;

   localparam int CMD_W       = 2;
   localparam int ANGLE_W     = 16;
   localparam int SPEED_W     = 8;
   localparam int STATUS_W    = 2;
   localparam int DIR_W       = 2;
   localparam int CPR_W       = 16;
   localparam int TOL_W       = 16;
   localparam int TIMEOUT_W   = 20;
   localparam int OUT_POS_W   = 32;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;
   localparam int REG_IDX_W   = 3;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RUN     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd3;

   localparam logic [REG_IDX_W-1:0] REG_CPR      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_REVERSE  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SPEED    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TOL      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;

   localparam logic [CPR_W-1:0]     CPR_RESET     = 16'd3278;
   localparam logic [SPEED_W-1:0]   SPEED_RESET   = 8'd255;
   localparam logic [TOL_W-1:0]     TOL_RESET     = 16'd4;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;
   localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 20'hFFFFF;

   // counts = floor(cpr * mag / 360) = floor(floor(prod / 8) / 45)
   localparam int PROD_W      = 31;
   localparam int DIV_IN_W    = 28;
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 34;
   localparam int QPROD_W     = DIV_IN_W + RECIP_W;
   localparam int COUNTS_W    = QPROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_45 = 29'd381774871;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic               neg;
      logic               nonzero;
      logic [ANGLE_W-1:0] mag;
   } cmd_type;

endpackage

// ===== sv/encmv_if.sv =====
// Valid/ready channel interfaces for move commands and motor results.
interface encmv_req_if;
   logic                                        valid;
   logic                                        ready;
   logic [encmv_pkg::CMD_W-1:0]                 cmd;
   logic signed [encmv_pkg::ANGLE_W-1:0]        angle_deg;

   modport source (output valid, cmd, angle_deg, input ready);
   modport sink (input valid, cmd, angle_deg, output ready);
endinterface

interface encmv_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        motor_enable;
   logic                                        motor_forward;
   logic [encmv_pkg::SPEED_W-1:0]               motor_speed;
   logic signed [encmv_pkg::OUT_POS_W-1:0]      position;
   logic [encmv_pkg::STATUS_W-1:0]              move_status;

   modport source (output valid, motor_enable, motor_forward, motor_speed, position,
                   move_status, input ready);
   modport sink (input valid, motor_enable, motor_forward, motor_speed, position,
                 move_status, output ready);
endinterface

// ===== sv/encoder_move_by_angle_core.sv =====
// Relative move controller for an encoder DC motor: pipeline, state and register file.
//
//   channel   direction  transfer when          payload
//   req_bus   in         valid & ready         cmd, angle_deg
//   rsp_bus   out        valid & ready         motor_enable, motor_forward, motor_speed,
//                                              position, move_status
//   apb       in         psel&penable&pwrite   paddr, pwdata (prdata on read)
//
// One item per cycle unless rsp_bus stalls; each result passes through the stages below.
// Stages: input register, cpr*|angle| multiply, reciprocal multiply for /360,
// then state update into the result register; all state changes there, in order.
// Each stage holds only when the next one is full and stalled.
// Reset is synchronous, active high; control, state and valid registers return to their reset values.
module encoder_move_by_angle_core #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   encmv_req_if.sink                     req_bus,
   encmv_rsp_if.source                   rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [encmv_pkg::ADDR_W-1:0]  paddr,
   input  logic [encmv_pkg::DATA_W-1:0]  pwdata,
   output logic [encmv_pkg::DATA_W-1:0]  prdata,
   output logic                          pready
);

   localparam int PW = POSITION_WIDTH;

   logic [encmv_pkg::CPR_W-1:0]     cpr_ff, cpr_in;
   logic                            rev_ff, rev_in;
   logic [encmv_pkg::SPEED_W-1:0]   speed_ff, speed_in;
   logic [encmv_pkg::TOL_W-1:0]     tol_ff, tol_in;
   logic [encmv_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;

   logic                              wr_en;
   logic [encmv_pkg::REG_IDX_W-1:0]   reg_idx;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s3_valid_ff, s3_valid_in;
   logic                         out_valid_ff, out_valid_in;
   encmv_pkg::cmd_type           s1_cmd_ff, s1_cmd_in;
   encmv_pkg::cmd_type           s2_cmd_ff, s2_cmd_in;
   encmv_pkg::cmd_type           s3_cmd_ff, s3_cmd_in;
   logic [encmv_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [encmv_pkg::COUNTS_W-1:0] counts_ff, counts_in;
   logic [encmv_pkg::QPROD_W-1:0]  qprod;

   logic rdy1, rdy2, rdy3, rdy_o, fire3;

   logic [PW-1:0]                   pos_ff, pos_in;
   logic [PW-1:0]                   err_ff, err_in;
   logic [encmv_pkg::DIR_W-1:0]     dir_ff, dir_in;
   logic                            running_ff, running_in;
   logic [encmv_pkg::TIMEOUT_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [encmv_pkg::STATUS_W-1:0]  outcome_ff, outcome_in;

   logic                            dneg;
   logic [PW-1:0]                   counts_pw, delta, err_mag;

   logic                              en_ff, en_in;
   logic                              fwd_ff, fwd_in;
   logic [encmv_pkg::SPEED_W-1:0]     ospeed_ff, ospeed_in;
   logic [encmv_pkg::OUT_POS_W-1:0]   opos_ff, opos_in;
   logic [encmv_pkg::STATUS_W-1:0]    ostatus_ff, ostatus_in;

   // register file
   assign pready  = 1'b1;
   assign reg_idx = paddr[encmv_pkg::ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cpr_in     = cpr_ff;
      rev_in     = rev_ff;
      speed_in   = speed_ff;
      tol_in     = tol_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         case (reg_idx)
            encmv_pkg::REG_CPR:     cpr_in     = pwdata[encmv_pkg::CPR_W-1:0];
            encmv_pkg::REG_REVERSE: rev_in     = pwdata[0];
            encmv_pkg::REG_SPEED:   speed_in   = pwdata[encmv_pkg::SPEED_W-1:0];
            encmv_pkg::REG_TOL:     tol_in     = pwdata[encmv_pkg::TOL_W-1:0];
            encmv_pkg::REG_TIMEOUT: timeout_in = pwdata[encmv_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         encmv_pkg::REG_CPR:     prdata = encmv_pkg::DATA_W'(cpr_ff);
         encmv_pkg::REG_REVERSE: prdata = encmv_pkg::DATA_W'(rev_ff);
         encmv_pkg::REG_SPEED:   prdata = encmv_pkg::DATA_W'(speed_ff);
         encmv_pkg::REG_TOL:     prdata = encmv_pkg::DATA_W'(tol_ff);
         encmv_pkg::REG_TIMEOUT: prdata = encmv_pkg::DATA_W'(timeout_ff);
         default:                prdata = '0;
      endcase
   end

   // pipeline flow
   assign rdy_o = !out_valid_ff || rsp_bus.ready;
   assign rdy3  = !s3_valid_ff || rdy_o;
   assign rdy2  = !s2_valid_ff || rdy3;
   assign rdy1  = !s1_valid_ff || rdy2;
   assign fire3 = s3_valid_ff && rdy_o;
   assign req_bus.ready = rdy1;

   assign s1_valid_in  = rdy1 ? req_bus.valid : s1_valid_ff;
   assign s2_valid_in  = rdy2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = rdy3 ? s2_valid_ff : s3_valid_ff;
   assign out_valid_in = rdy_o ? s3_valid_ff : out_valid_ff;

   always_comb begin
      s1_cmd_in         = s1_cmd_ff;
      if (rdy1) begin
         s1_cmd_in.cmd     = req_bus.cmd;
         s1_cmd_in.neg     = req_bus.angle_deg[encmv_pkg::ANGLE_W-1];
         s1_cmd_in.nonzero = (req_bus.angle_deg != '0);
         s1_cmd_in.mag     = req_bus.angle_deg[encmv_pkg::ANGLE_W-1]
                             ? encmv_pkg::ANGLE_W'(-req_bus.angle_deg)
                             : req_bus.angle_deg;
      end
   end

   assign s2_cmd_in = rdy2 ? s1_cmd_ff : s2_cmd_ff;
   assign prod_in   = rdy2 ? encmv_pkg::PROD_W'(cpr_ff) * encmv_pkg::PROD_W'(s1_cmd_ff.mag)
                           : prod_ff;

   assign qprod     = encmv_pkg::QPROD_W'(prod_ff[encmv_pkg::PROD_W-1:3])
                      * encmv_pkg::QPROD_W'(encmv_pkg::RECIP_45);
   assign s3_cmd_in = rdy3 ? s2_cmd_ff : s3_cmd_ff;
   assign counts_in = rdy3 ? qprod[encmv_pkg::QPROD_W-1:encmv_pkg::RECIP_SHIFT] : counts_ff;

   // move state
   assign dneg        = s3_cmd_ff.neg ^ rev_ff;
   assign counts_pw   = PW'(counts_ff);
   assign delta       = dneg ? (PW'(0) - counts_pw) : counts_pw;
   assign err_mag     = err_ff[PW-1] ? (PW'(0) - err_ff) : err_ff;
   assign elapsed_inc = (elapsed_ff == encmv_pkg::ELAPSED_MAX) ? elapsed_ff
                        : elapsed_ff + encmv_pkg::TIMEOUT_W'(1);

   always_comb begin
      pos_in     = pos_ff;
      err_in     = err_ff;
      dir_in     = dir_ff;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      outcome_in = outcome_ff;
      if (fire3) begin
         case (s3_cmd_ff.cmd)
            encmv_pkg::CMD_START: begin
               if (!running_ff && s3_cmd_ff.nonzero) begin
                  err_in     = delta;
                  dir_in     = (!dneg && counts_ff != '0) ? encmv_pkg::DIR_FWD
                                                          : encmv_pkg::DIR_BWD;
                  running_in = 1'b1;
                  elapsed_in = '0;
               end
            end
            encmv_pkg::CMD_EDGE: begin
               if (dir_ff == encmv_pkg::DIR_FWD) begin
                  pos_in = pos_ff + PW'(1);
                  err_in = err_ff - PW'(1);
               end else if (dir_ff == encmv_pkg::DIR_BWD) begin
                  pos_in = pos_ff - PW'(1);
                  err_in = err_ff + PW'(1);
               end
            end
            encmv_pkg::CMD_TICK: begin
               if (running_ff) begin
                  elapsed_in = elapsed_inc;
                  if (err_mag <= PW'(tol_ff)) begin
                     running_in = 1'b0;
                     dir_in     = encmv_pkg::DIR_STOP;
                     outcome_in = encmv_pkg::STATUS_DONE;
                  end else if (elapsed_inc > timeout_ff) begin
                     running_in = 1'b0;
                     dir_in     = encmv_pkg::DIR_STOP;
                     outcome_in = encmv_pkg::STATUS_TIMEOUT;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      en_in      = en_ff;
      fwd_in     = fwd_ff;
      ospeed_in  = ospeed_ff;
      opos_in    = opos_ff;
      ostatus_in = ostatus_ff;
      if (fire3) begin
         en_in      = running_in;
         fwd_in     = running_in && (dir_in == encmv_pkg::DIR_FWD);
         ospeed_in  = running_in ? speed_ff : '0;
         opos_in    = encmv_pkg::OUT_POS_W'($signed(pos_in));
         ostatus_in = running_in ? encmv_pkg::STATUS_RUN : outcome_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.motor_enable  = en_ff;
   assign rsp_bus.motor_forward = fwd_ff;
   assign rsp_bus.motor_speed   = ospeed_ff;
   assign rsp_bus.position      = opos_ff;
   assign rsp_bus.move_status   = ostatus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff       <= encmv_pkg::CPR_RESET;
         rev_ff       <= 1'b0;
         speed_ff     <= encmv_pkg::SPEED_RESET;
         tol_ff       <= encmv_pkg::TOL_RESET;
         timeout_ff   <= encmv_pkg::TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         err_ff       <= '0;
         dir_ff       <= encmv_pkg::DIR_STOP;
         running_ff   <= 1'b0;
         elapsed_ff   <= '0;
         outcome_ff   <= encmv_pkg::STATUS_IDLE;
      end else begin
         cpr_ff       <= cpr_in;
         rev_ff       <= rev_in;
         speed_ff     <= speed_in;
         tol_ff       <= tol_in;
         timeout_ff   <= timeout_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         dir_ff       <= dir_in;
         running_ff   <= running_in;
         elapsed_ff   <= elapsed_in;
         outcome_ff   <= outcome_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff  <= s1_cmd_in;
      s2_cmd_ff  <= s2_cmd_in;
      s3_cmd_ff  <= s3_cmd_in;
      prod_ff    <= prod_in;
      counts_ff  <= counts_in;
      en_ff      <= en_in;
      fwd_ff     <= fwd_in;
      ospeed_ff  <= ospeed_in;
      opos_ff    <= opos_in;
      ostatus_ff <= ostatus_in;
   end

endmodule

// ===== sv/encmv_checker.sv =====
// Port-level assertions for the encoder move controller, bound to the top level.
module encmv_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  motor_enable,
   input logic                                  motor_forward,
   input logic [encmv_pkg::SPEED_W-1:0]         motor_speed,
   input logic [encmv_pkg::STATUS_W-1:0]        move_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_enable_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (motor_enable == (move_status == encmv_pkg::STATUS_RUN)))
      else $error("motor enable disagrees with move status");

   a_forward_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && motor_forward |-> motor_enable)
      else $error("forward drive while motor disabled");

   a_speed_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !motor_enable |-> (motor_speed == '0))
      else $error("nonzero speed while motor disabled");

endmodule

bind encoder_move_by_angle_core encmv_checker u_encmv_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .motor_enable  (rsp_bus.motor_enable),
   .motor_forward (rsp_bus.motor_forward),
   .motor_speed   (rsp_bus.motor_speed),
   .move_status   (rsp_bus.move_status)
);
